// ----- hdl/utf8sd_pkg.sv -----
package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int PEND_W = 2;

    localparam logic [CP_W-1:0] MIN_CP_2B = 21'h00_0080;
    localparam logic [CP_W-1:0] MIN_CP_3B = 21'h00_0800;
    localparam logic [CP_W-1:0] MIN_CP_4B = 21'h01_0000;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10_FFFF;

    localparam logic [LEN_W-1:0] LEN_1B = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2B = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3B = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4B = 3'd4;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef enum logic [2:0] {
        ST_CODEPOINT = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_OVERLONG  = 3'd4,
        ST_ABOVE_MAX = 3'd5,
        ST_END_ONLY  = 3'd6
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_length;
        t_status          status;
        logic             text_done;
        logic             text_valid;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [BYTE_W-1:0] text_byte;
        logic             end_of_text;
    } t_in_item;

endpackage

// ----- hdl/utf8sd_in_stage.sv -----
module utf8sd_in_stage
    import utf8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_end_of_text,
    input  logic              i_advance,
    output t_in_item          o_item
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_text_byte;
    logic              r_end_of_text;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_text_byte   <= i_text_byte;
            r_end_of_text <= i_end_of_text;
        end
    end

    assign o_item = '{valid: r_valid, text_byte: r_text_byte, end_of_text: r_end_of_text};

endmodule

// ----- hdl/utf8sd_core.sv -----
module utf8sd_core
    import utf8sd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  logic     i_fire,
    output logic     o_has_result,
    output t_result  o_result
);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [CP_W-1:0]   r_accum, n_accum;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_err, n_err;

    logic [CP_W-1:0]   shifted;
    logic [CP_W-1:0]   cp;
    logic [LEN_W-1:0]  len;
    logic              err;
    t_status           err_code;
    logic              complete;
    logic [BYTE_W-1:0] b;
    logic              eot;

    assign b       = i_item.text_byte;
    assign eot     = i_item.end_of_text;
    assign shifted = {r_accum[CP_W-7:0], b[5:0]};

    always_comb begin
        n_pending    = r_pending;
        n_accum      = r_accum;
        n_len        = r_len;
        n_err        = r_err;
        cp           = '0;
        len          = '0;
        err          = 1'b0;
        err_code     = ST_CODEPOINT;
        complete     = 1'b0;
        o_has_result = 1'b0;
        o_result     = '{codepoint: '0, seq_length: '0, status: ST_CODEPOINT,
                         text_done: 1'b0, text_valid: 1'b0};

        if (r_err) begin
            if (eot) begin
                o_has_result       = 1'b1;
                o_result.status    = ST_END_ONLY;
                o_result.text_done = 1'b1;
                n_pending          = '0;
                n_accum            = '0;
                n_len              = '0;
                n_err              = 1'b0;
            end
        end else begin
            if (r_pending == '0) begin
                if (b inside {[8'h00:8'h7F]}) begin
                    cp       = {{(CP_W-BYTE_W){1'b0}}, b};
                    len      = LEN_1B;
                    complete = 1'b1;
                end else if (b inside {[8'hC0:8'hDF]}) begin
                    n_accum   = {{(CP_W-5){1'b0}}, b[4:0]};
                    n_len     = LEN_2B;
                    n_pending = 2'd1;
                end else if (b inside {[8'hE0:8'hEF]}) begin
                    n_accum   = {{(CP_W-4){1'b0}}, b[3:0]};
                    n_len     = LEN_3B;
                    n_pending = 2'd2;
                end else if (b inside {[8'hF0:8'hF7]}) begin
                    n_accum   = {{(CP_W-3){1'b0}}, b[2:0]};
                    n_len     = LEN_4B;
                    n_pending = 2'd3;
                end else begin
                    err      = 1'b1;
                    err_code = ST_BAD_LEAD;
                end
            end else if (b[7:6] != CONT_TAG) begin
                err      = 1'b1;
                err_code = ST_BAD_CONT;
            end else begin
                n_accum   = shifted;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    cp  = shifted;
                    len = r_len;
                    case (r_len)
                        LEN_2B: begin
                            err = shifted < MIN_CP_2B;
                        end
                        LEN_3B: begin
                            err = shifted < MIN_CP_3B;
                        end
                        LEN_4B: begin
                            err = (shifted < MIN_CP_4B) || (shifted > MAX_CP);
                        end
                        default: begin
                            err = 1'b0;
                        end
                    endcase
                    if (r_len == LEN_4B && shifted > MAX_CP) begin
                        err_code = ST_ABOVE_MAX;
                    end else begin
                        err_code = ST_OVERLONG;
                    end
                    complete = !err;
                end
            end

            if (err) begin
                o_has_result       = 1'b1;
                o_result.status    = err_code;
                o_result.text_done = eot;
                n_pending          = '0;
                n_accum            = '0;
                n_len              = '0;
                n_err              = !eot;
            end else if (complete) begin
                o_has_result        = 1'b1;
                o_result.codepoint  = cp;
                o_result.seq_length = len;
                o_result.text_done  = eot;
                o_result.text_valid = eot;
                n_pending           = '0;
                n_accum             = '0;
                n_len               = '0;
                n_err               = 1'b0;
            end else if (eot) begin
                o_has_result       = 1'b1;
                o_result.status    = ST_TRUNCATED;
                o_result.text_done = 1'b1;
                n_pending          = '0;
                n_accum            = '0;
                n_len              = '0;
                n_err              = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_accum   <= '0;
            r_len     <= '0;
            r_err     <= 1'b0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_len     <= n_len;
            r_err     <= n_err;
        end
    end

endmodule

// ----- hdl/utf8sd_out_stage.sv -----
module utf8sd_out_stage
    import utf8sd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hdl/utf8_stream_decoder.sv -----
// utf8_stream_decoder: streaming utf-8 decoder and validator
//
// input channel: i_valid / o_ready carry one item, a text byte plus an
// end-of-text flag marking the last byte of the text
// output channel: o_valid / i_ready carry one result item: codepoint, sequence
// length, status, text_done and text_valid
// a lead byte or a middle continuation byte gives no result; the byte that
// completes a sequence, any error, and the end-of-text byte give one result
// after an error, bytes give nothing until end of text, which reports status
// end-only with text_valid low
//
// throughput: one item per cycle while the result register is free, set by the single
// decode step between the input register and the result register
// a result passes from the input register through the result register to o_valid
// reset (i_rst_n low, synchronous) empties both registers and clears the
// decoder state, so the next byte starts a new text
// when the receiver stalls, the result register holds, the input register
// still takes one more item, and o_ready then drops until space frees up
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_end_of_text,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CP_W-1:0]   o_codepoint,
    output logic [LEN_W-1:0]  o_seq_length,
    output logic [2:0]        o_status,
    output logic              o_text_done,
    output logic              o_text_valid
);

    t_in_item in_item;
    logic     out_free;
    logic     fire;
    logic     has_result;
    t_result  core_result;
    t_result  out_result;

    assign fire = in_item.valid && out_free;

    utf8sd_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_advance     (fire),
        .o_item        (in_item)
    );

    utf8sd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_item),
        .i_fire       (fire),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    utf8sd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && has_result),
        .i_result (core_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_codepoint  = out_result.codepoint;
    assign o_seq_length = out_result.seq_length;
    assign o_status     = out_result.status;
    assign o_text_done  = out_result.text_done;
    assign o_text_valid = out_result.text_valid;

endmodule

// ----- hdl/utf8sd_checker.sv -----
module utf8sd_checker
    import utf8sd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CP_W-1:0]   o_codepoint,
    input logic [LEN_W-1:0]  o_seq_length,
    input logic [2:0]        o_status
    ,
    input logic              o_text_done,
    input logic              o_text_valid
);

    // error and end-only items carry no codepoint
    a_no_cp_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_CODEPOINT) |-> (o_codepoint == '0 && o_seq_length == '0))
        else $error("codepoint or length set on an error item");

    a_valid_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_valid) |-> (o_text_done && o_status == ST_CODEPOINT))
        else $error("text_valid on a non-final or failed item");

    a_length_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_CODEPOINT) |->
            ((o_seq_length == LEN_1B && o_codepoint < MIN_CP_2B) ||
             (o_seq_length == LEN_2B && o_codepoint >= MIN_CP_2B && o_codepoint < MIN_CP_3B) ||
             (o_seq_length == LEN_3B && o_codepoint >= MIN_CP_3B && o_codepoint < MIN_CP_4B) ||
             (o_seq_length == LEN_4B && o_codepoint >= MIN_CP_4B && o_codepoint <= MAX_CP)))
        else $error("codepoint out of range for its sequence length");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_codepoint) && $stable(o_status)))
        else $error("result item changed while stalled");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_codepoint  (o_codepoint),
    .o_seq_length (o_seq_length),
    .o_status     (o_status),
    .o_text_done  (o_text_done),
    .o_text_valid (o_text_valid)
);

// ----- bench/utf8_result_check.sv -----
`timescale 1ns / 1ps
module utf8_result_check
    import utf8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_end_of_text,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [CP_W-1:0]   i_codepoint,
    input  logic [LEN_W-1:0]  i_seq_length,
    input  logic [2:0]        i_status,
    input  logic              i_text_done,
    input  logic              i_text_valid,
    output int                o_fail_count,
    output int                o_awaited,
    output int                o_results_seen
);

    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   partial_cp;
    logic [LEN_W-1:0]  open_len;
    logic              text_broken;
    t_result           awaited_results[$];
    int                fails;
    int                seen;

    task automatic note_failure(input string msg);
        if (fails < 200) begin
            $display("mismatch at result item %0d: %s", seen, msg);
        end
        fails++;
    endtask

    task automatic clear_text();
        cont_left   = '0;
        partial_cp  = '0;
        open_len    = '0;
        text_broken = 1'b0;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_result r;
        logic    emit;
        logic    ok;
        r = '0;
        r.text_done = last;
        emit = 1'b0;
        ok = 1'b0;
        if (text_broken) begin
            if (last) begin
                r.status = ST_END_ONLY;
                emit = 1'b1;
            end
        end else if (cont_left == '0) begin
            if (!b[7]) begin
                r.codepoint = CP_W'(b);
                r.seq_length = LEN_1B;
                ok = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                partial_cp = CP_W'(b[4:0]);
                open_len = LEN_2B;
                cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                partial_cp = CP_W'(b[3:0]);
                open_len = LEN_3B;
                cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                partial_cp = CP_W'(b[2:0]);
                open_len = LEN_4B;
                cont_left = 2'd3;
            end else begin
                r.status = ST_BAD_LEAD;
                emit = 1'b1;
            end
        end else if (b[7:6] != CONT_TAG) begin
            r.status = ST_BAD_CONT;
            emit = 1'b1;
        end else begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == '0) begin
                if ((open_len == LEN_2B && partial_cp < MIN_CP_2B) ||
                    (open_len == LEN_3B && partial_cp < MIN_CP_3B) ||
                    (open_len == LEN_4B && partial_cp < MIN_CP_4B)) begin
                    r.status = ST_OVERLONG;
                    emit = 1'b1;
                end else if (open_len == LEN_4B && partial_cp > MAX_CP) begin
                    r.status = ST_ABOVE_MAX;
                    emit = 1'b1;
                end else begin
                    r.codepoint = partial_cp;
                    r.seq_length = open_len;
                    ok = 1'b1;
                end
            end
        end

        if (ok) begin
            r.text_valid = last;
            emit = 1'b1;
            clear_text();
        end else if (emit) begin
            // errors before the last byte mute the rest of the text
            clear_text();
            text_broken = !last;
        end else if (last) begin
            r.status = ST_TRUNCATED;
            emit = 1'b1;
            clear_text();
        end
        if (emit) begin
            awaited_results = {awaited_results, r};
        end
    endtask

    task automatic compare_result(input t_result want);
        if (i_codepoint !== want.codepoint) begin
            note_failure($sformatf("codepoint %h, expected %h", i_codepoint, want.codepoint));
        end
        if (i_seq_length !== want.seq_length) begin
            note_failure($sformatf("seq_length %0d, expected %0d",
                                   i_seq_length, want.seq_length));
        end
        if (i_status !== want.status) begin
            note_failure($sformatf("status %0d, expected %0d", i_status, want.status));
        end
        if (i_text_done !== want.text_done) begin
            note_failure($sformatf("text_done %b, expected %b", i_text_done, want.text_done));
        end
        if (i_text_valid !== want.text_valid) begin
            note_failure($sformatf("text_valid %b, expected %b",
                                   i_text_valid, want.text_valid));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (awaited_results.size() == 0) begin
                    note_failure("result item with nothing awaited");
                end else begin
                    compare_result(awaited_results.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_text_byte, i_end_of_text);
            end
        end
        o_fail_count   <= fails;
        o_awaited      <= awaited_results.size();
        o_results_seen <= seen;
    end

endmodule

// ----- bench/tb_utf8_stream_decoder.sv -----
`timescale 1ns / 1ps
module tb_utf8_stream_decoder;
    import utf8sd_pkg::*;

    localparam int TOTAL_ITEMS = 1600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [BYTE_W-1:0] i_text_byte = '0;
    logic              i_end_of_text = 1'b0;
    logic              i_ready = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [CP_W-1:0]   o_codepoint;
    logic [LEN_W-1:0]  o_seq_length;
    logic [2:0]        o_status;
    logic              o_text_done;
    logic              o_text_valid;

    int                fail_count;
    int                awaited;
    int                results_seen;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                hold_request;
    int                items_sent;
    int                texts_sent;
    int                flawed_texts;
    int                cycles;
    logic [BYTE_W-1:0] text_bytes[$];

    utf8_stream_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_codepoint  (o_codepoint),
        .o_seq_length (o_seq_length),
        .o_status     (o_status),
        .o_text_done  (o_text_done),
        .o_text_valid (o_text_valid)
    );

    utf8_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_codepoint   (o_codepoint),
        .i_seq_length  (o_seq_length),
        .i_status      (o_status),
        .i_text_done   (o_text_done),
        .i_text_valid  (o_text_valid),
        .o_fail_count  (fail_count),
        .o_awaited     (awaited),
        .o_results_seen(results_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, plus one long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_text_byte <= b;
        i_end_of_text <= last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_bytes.size(); k++) begin
            send_item(text_bytes[k], k == text_bytes.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
    endtask

    function automatic void append_byte(input logic [BYTE_W-1:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic logic [CP_W-1:0] pick_cp(input int unsigned lo, input int unsigned hi);
        int unsigned r = $urandom_range(0, 7);
        if (r == 0) begin
            return CP_W'(lo);
        end
        if (r == 1) begin
            return CP_W'(hi);
        end
        return CP_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [CP_W-1:0] cp_for(input logic [LEN_W-1:0] len, input bit overlong);
        case (len)
            LEN_1B: return pick_cp(0, MIN_CP_2B - 1);
            LEN_2B: return overlong ? pick_cp(0, MIN_CP_2B - 1)
                                    : pick_cp(MIN_CP_2B, MIN_CP_3B - 1);
            LEN_3B: return overlong ? pick_cp(0, MIN_CP_3B - 1)
                                    : pick_cp(MIN_CP_3B, MIN_CP_4B - 1);
            default: return overlong ? pick_cp(0, MIN_CP_4B - 1)
                                     : pick_cp(MIN_CP_4B, MAX_CP);
        endcase
    endfunction

    function automatic void push_seq(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len);
        case (len)
            LEN_1B: append_byte({1'b0, cp[6:0]});
            LEN_2B: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({CONT_TAG, cp[5:0]});
            end
            LEN_3B: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({CONT_TAG, cp[11:6]});
                append_byte({CONT_TAG, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({CONT_TAG, cp[17:12]});
                append_byte({CONT_TAG, cp[11:6]});
                append_byte({CONT_TAG, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void push_valid();
        int unsigned      r = $urandom_range(0, 9);
        logic [LEN_W-1:0] len;
        len = (r < 4) ? LEN_1B : (r < 6) ? LEN_2B : (r < 8) ? LEN_3B : LEN_4B;
        push_seq(cp_for(len, 1'b0), len);
    endfunction

    // returns 1 when the flaw is a cut sequence that must end the text
    function automatic bit push_flawed();
        int unsigned       flaw = $urandom_range(0, 5);
        logic [LEN_W-1:0]  len = LEN_2B + LEN_W'($urandom_range(0, 2));
        int unsigned       first = text_bytes.size();
        logic [BYTE_W-1:0] junk = BYTE_W'($urandom);
        case (flaw)
            0: push_seq(cp_for(len, 1'b1), len);
            1: push_seq(pick_cp(MAX_CP + 1, 21'h1F_FFFF), LEN_4B);
            2: append_byte({CONT_TAG, junk[5:0]});
            3: append_byte({5'b11111, junk[2:0]});
            4: begin
                push_seq(cp_for(len, 1'b0), len);
                if (junk[7:6] == CONT_TAG) begin
                    junk[7] = 1'b0;
                end
                text_bytes[first + $urandom_range(1, int'(len) - 1)] = junk;
            end
            default: begin
                push_seq(cp_for(len, 1'b0), len);
                while (text_bytes.size() > first + $urandom_range(1, int'(len) - 1)) begin
                    void'(text_bytes.pop_back());
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic build_text();
        int unsigned kind = $urandom_range(0, 99);
        int unsigned n_elem = $urandom_range(1, 6);
        int unsigned bad_at = $urandom_range(0, n_elem - 1);
        text_bytes.delete();
        if (kind >= 70) begin
            flawed_texts++;
        end
        if (kind >= 92) begin
            repeat ($urandom_range(1, 6)) append_byte(BYTE_W'($urandom));
        end else begin
            for (int k = 0; k < n_elem; k++) begin
                if (kind >= 70 && k == bad_at) begin
                    if (push_flawed()) begin
                        break;
                    end
                end else begin
                    push_valid();
                end
            end
        end
    endtask

    initial begin
        int phase_end;
        tx_idle_pct = 18;
        rx_idle_pct = 50;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed texts
        text_bytes = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF};
        send_text();
        text_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hED, 8'hA0, 8'h80};
        send_text();
        text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        text_bytes = '{8'hC0, 8'h80};
        send_text();
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();
        text_bytes = '{8'hF8};
        send_text();
        text_bytes = '{8'h80, 8'hFF};
        send_text();
        text_bytes = '{8'hC2, 8'h41};
        send_text();
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 50 : 0;
            rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 18 : 0;
            if (phase != 1) begin
                hold_request = 1'b1;
            end
            phase_end = items_sent + TOTAL_ITEMS / 3;
            while (items_sent < phase_end) begin
                build_text();
                send_text();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d bytes in %0d texts, %0d of them flawed, over three idle mixes",
                 items_sent, texts_sent, flawed_texts);
        $display("checked %0d result items, with long output holds and full drains",
                 results_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/utf8sd_pkg.sv
hdl/utf8sd_in_stage.sv
hdl/utf8sd_core.sv
hdl/utf8sd_out_stage.sv
hdl/utf8_stream_decoder.sv
hdl/utf8sd_checker.sv
bench/utf8_result_check.sv
bench/tb_utf8_stream_decoder.sv
